>>> rtl/lru_key_cache_directory_macros.svh
// Assertion macros shared by the key cache directory RTL.
// Depends on nothing; the asserting module must provide clk and arst_n.
`ifndef LRU_KEY_CACHE_DIRECTORY_MACROS_SVH
`define LRU_KEY_CACHE_DIRECTORY_MACROS_SVH
`ifndef ASSERT_OFF
`define LKCD_ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LKCD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define LKCD_ASSERT_PROP(lbl, prop, msg)
`define LKCD_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/lkcd_pkg.sv
// Constants and types of the LRU key cache directory.
// Used by lkcd_cell, lru_key_cache_directory and the testbench; depends on nothing.
package lkcd_pkg;
	localparam int ENTRIES    = 8;
	localparam int KEY_BITS   = 64;
	localparam int POS_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int KEY_W      = 64;
	localparam int SLOT_W     = 3;
	localparam int FILL_W     = 4;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 80;

	typedef struct packed {
		logic capture;
		logic active;
		logic shift;
		logic is_pos;
	} lkcd_cell_ctl_t;
endpackage

>>> rtl/lkcd_cell.sv
// One recency position of the directory: a key, its slot and a match flag.
// Depends on lkcd_pkg; instantiated in a chain by lru_key_cache_directory.
module lkcd_cell
	import lkcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lkcd_cell_ctl_t      ctl,
	input  logic [POS_W-1:0]    idx,
	input  logic [KEY_BITS-1:0] cmp_key,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic [POS_W-1:0]    prev_slot,
	input  logic                seen_in,
	input  logic [POS_W-1:0]    slot_in,
	output logic [KEY_BITS-1:0] key,
	output logic [POS_W-1:0]    slot,
	output logic                seen_out,
	output logic                first,
	output logic [POS_W-1:0]    slot_out
);
	logic [KEY_BITS-1:0] key_q;
	logic [POS_W-1:0]    slot_x_q;
	logic                match_q;

	// The slot is stored relative to the position index so that reset gives index order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_x_q <= '0;
			match_q  <= 1'b0;
		end else begin
			if (ctl.capture) begin
				match_q <= ctl.active && (key_q == cmp_key);
			end
			if (ctl.shift) begin
				slot_x_q <= prev_slot ^ idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= prev_key;
		end
	end

	assign key      = key_q;
	assign slot     = slot_x_q ^ idx;
	assign first    = match_q & ~seen_in;
	assign seen_out = seen_in | match_q;
	assign slot_out = ctl.is_pos ? (slot_in | slot) : slot_in;
endmodule

>>> rtl/lru_key_cache_directory.sv
// Top level of the fully associative LRU key cache directory.
// Depends on lkcd_pkg, lkcd_cell and lru_key_cache_directory_macros.svh.
//
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   s_tuser = cmd, s_tdata = key
// m        out  m_tvalid/m_tready   m_tdata = hit, slot, evicted, evicted_key, fill
//
// For each request, the accept edge registers every cell's key compare,
// and the update edge then moves the chosen entry to the front of the cell chain.
// A new request is taken as soon as the previous update has been written.
// The update waits while the output register holds a result not yet taken.
// Reset empties the directory; there is no clearing pass.
`include "lru_key_cache_directory_macros.svh"
module lru_key_cache_directory
	import lkcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [63:0] key
	input  logic                  s_tuser,  // [0] cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [0] hit, [3:1] slot, [4] evicted,
	                                        // [68:5] evicted_key, [72:69] fill
);
	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t                  state_q;
	logic                    cmd_s1;
	logic [KEY_BITS-1:0]     key_s1;
	logic [CNT_W-1:0]        fill_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	logic [KEY_BITS-1:0]     cell_key [ENTRIES];
	logic [POS_W-1:0]        cell_slot [ENTRIES];
	logic [ENTRIES:0]        seen_chain;
	logic [POS_W-1:0]        slot_chain [ENTRIES+1];
	logic [ENTRIES-1:0]      first_vec;
	lkcd_cell_ctl_t          cell_ctl [ENTRIES];

	logic                    capture;
	logic                    upd_go;
	logic                    hit;
	logic                    ins_full;
	logic [POS_W-1:0]        ins_pos;
	logic [POS_W-1:0]        pos_slot;
	logic [CNT_W-1:0]        fill_next;
	logic [KEY_W-1:0]        ev_key;
	logic [ENTRIES-1:0]      slot_present;

	assign s_tready = (state_q == ST_IDLE);
	assign capture  = s_tvalid && s_tready;
	assign upd_go   = (state_q == ST_UPD) && (!m_tvalid_q || m_tready);
	assign hit      = !cmd_s1 && seen_chain[ENTRIES];
	assign ins_full = (fill_q == CNT_W'(ENTRIES));
	assign ins_pos  = ins_full ? POS_W'(ENTRIES - 1) : fill_q[POS_W-1:0];
	assign pos_slot = slot_chain[ENTRIES];

	assign seen_chain[0] = 1'b0;
	assign slot_chain[0] = '0;

	for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
		logic [KEY_BITS-1:0] prev_key;
		logic [POS_W-1:0]    prev_slot;

		if (p == 0) begin : g_head
			assign prev_key  = key_s1;
			assign prev_slot = pos_slot;
		end else begin : g_link
			assign prev_key  = cell_key[p-1];
			assign prev_slot = cell_slot[p-1];
		end

		always_comb begin
			cell_ctl[p].capture = capture;
			cell_ctl[p].active  = CNT_W'(p) < fill_q;
			if (cmd_s1) begin
				cell_ctl[p].is_pos = (POS_W'(p) == ins_pos);
				cell_ctl[p].shift  = upd_go && (POS_W'(p) <= ins_pos);
			end else begin
				cell_ctl[p].is_pos = first_vec[p];
				cell_ctl[p].shift  = upd_go && seen_chain[ENTRIES] && !seen_chain[p];
			end
		end

		lkcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl[p]),
			.idx       (POS_W'(p)),
			.cmp_key   (s_tdata[KEY_BITS-1:0]),
			.prev_key  (prev_key),
			.prev_slot (prev_slot),
			.seen_in   (seen_chain[p]),
			.slot_in   (slot_chain[p]),
			.key       (cell_key[p]),
			.slot      (cell_slot[p]),
			.seen_out  (seen_chain[p+1]),
			.first     (first_vec[p]),
			.slot_out  (slot_chain[p+1])
		);
	end

	always_comb begin
		fill_next = fill_q;
		ev_key    = '0;
		if (cmd_s1) begin
			if (ins_full) begin
				ev_key = KEY_W'(cell_key[ENTRIES-1]);
			end else begin
				fill_next = fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
			cmd_s1     <= 1'b0;
			key_s1     <= '0;
			m_tdata_q  <= '0;
		end else begin
			if (upd_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (capture) begin
						cmd_s1  <= s_tuser;
						key_s1  <= s_tdata[KEY_BITS-1:0];
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_go) begin
						fill_q     <= fill_next;
						m_tdata_q  <= {7'd0,
						               FILL_W'(fill_next),
						               ev_key,
						               cmd_s1 && ins_full,
						               SLOT_W'(pos_slot),
						               hit};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		slot_present = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_present[cell_slot[i]] = 1'b1;
		end
	end

	`LKCD_ASSERT_NEVER(a_fill_range, fill_q > CNT_W'(ENTRIES), "fill beyond capacity")
	`LKCD_ASSERT_PROP(a_first_onehot, $onehot0(first_vec), "more than one first match")
	`LKCD_ASSERT_PROP(a_slot_perm, &slot_present, "slot order is not a permutation")
	`LKCD_ASSERT_PROP(a_fill_grow, (upd_go && cmd_s1) |=> (fill_q != '0), "insert left no entry")
endmodule

>>> tb/tb.sv
// Self-checking testbench for lru_key_cache_directory: lookups and inserts are streamed in,
// and every result is compared with a recency-ordered directory model kept inside the bench.
// Depends on lkcd_pkg and the lru_key_cache_directory RTL.
`timescale 1ns / 1ps
module tb;
	import lkcd_pkg::*;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_INSERT = 1'b1
	} dir_cmd_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
		logic [FILL_W-1:0] fill;
	} dir_result_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic [KEY_W-1:0] dir_keys [ENTRIES];
	logic             dir_valid [ENTRIES];
	int               dir_order [ENTRIES];
	int               dir_count;

	dir_result_t pending_results [$];
	dir_result_t expected_result;
	int          errors;
	int          idle_pct;
	int          stall_pct;
	int          cycle_count;

	lru_key_cache_directory dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void move_to_front(int pos);
		int s;
		s = dir_order[pos];
		for (int p = pos; p > 0; p--) begin
			dir_order[p] = dir_order[p - 1];
		end
		dir_order[0] = s;
	endfunction

	function automatic dir_result_t predict_directory(dir_cmd_t c, logic [KEY_W-1:0] k);
		dir_result_t r;
		int          s;
		int          hit_pos;
		r = '0;
		hit_pos = -1;
		if (c == CMD_LOOKUP) begin
			for (int p = 0; p < dir_count && hit_pos < 0; p++) begin
				s = dir_order[p];
				if (dir_valid[s] && dir_keys[s] == k) begin
					hit_pos = p;
					r.hit = 1'b1;
					r.slot = SLOT_W'(s);
				end
			end
			if (hit_pos >= 0) begin
				move_to_front(hit_pos);
			end
		end else begin
			if (dir_count == ENTRIES) begin
				s = dir_order[ENTRIES - 1];
				r.evicted = 1'b1;
				r.evicted_key = dir_keys[s];
				dir_valid[s] = 1'b0;
				dir_count--;
			end
			s = dir_order[dir_count];
			dir_keys[s] = k;
			dir_valid[s] = 1'b1;
			move_to_front(dir_count);
			dir_count++;
			r.slot = SLOT_W'(s);
		end
		r.fill = FILL_W'(dir_count);
		return r;
	endfunction

	function automatic void check_field(string name, logic [KEY_W-1:0] exp_val,
			logic [KEY_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			errors++;
		end
	endfunction

	always @(negedge clk) begin
		m_tready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				expected_result = pending_results.pop_front();
				check_field("hit", expected_result.hit, m_tdata[0]);
				check_field("slot", expected_result.slot, m_tdata[3:1]);
				check_field("evicted", expected_result.evicted, m_tdata[4]);
				check_field("evicted_key", expected_result.evicted_key, m_tdata[68:5]);
				check_field("fill", expected_result.fill, m_tdata[72:69]);
			end
		end
	end

	task automatic send_request(input dir_cmd_t c, input logic [KEY_W-1:0] k);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = c;
		s_tdata = k;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_results.push_back(predict_directory(c, k));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic test_empty_directory();
		send_request(CMD_LOOKUP, '0);
		send_request(CMD_LOOKUP, KEY_ONES);
		drain_results();
	endtask

	task automatic test_fill_and_hit();
		send_request(CMD_INSERT, '0);
		send_request(CMD_INSERT, KEY_ONES);
		send_request(CMD_INSERT, 64'h5555_5555_5555_5555);
		send_request(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_LOOKUP, KEY_ONES);
		send_request(CMD_LOOKUP, '0);
		send_request(CMD_LOOKUP, 64'h1);
		drain_results();
	endtask

	task automatic test_duplicate_keys();
		send_request(CMD_INSERT, KEY_ONES);
		send_request(CMD_LOOKUP, KEY_ONES);
		drain_results();
	endtask

	task automatic test_eviction();
		send_request(CMD_INSERT, 64'h0123_4567_89AB_CDEF);
		send_request(CMD_INSERT, 64'hFEDC_BA98_7654_3210);
		send_request(CMD_INSERT, 64'h8000_0000_0000_0001);
		send_request(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFE);
		send_request(CMD_INSERT, 64'hDEAD_BEEF_0000_FFFF);
		send_request(CMD_LOOKUP, 64'h5555_5555_5555_5555);
		send_request(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_INSERT, 64'h0000_0000_0000_0002);
		drain_results();
	endtask

	task automatic test_random_traffic(input int n_items, input int idle, input int stall);
		logic [KEY_W-1:0] key_pool [12];
		logic [KEY_W-1:0] k;
		dir_cmd_t         c;
		idle_pct = idle;
		stall_pct = stall;
		foreach (key_pool[j]) begin
			key_pool[j] = {$urandom, $urandom};
		end
		for (int i = 0; i < n_items; i++) begin
			c = ($urandom_range(1) == 1) ? CMD_INSERT : CMD_LOOKUP;
			if ($urandom_range(99) < 70) begin
				k = key_pool[$urandom_range(11)];
			end else begin
				k = {$urandom, $urandom};
			end
			if (i == n_items / 2) begin
				drain_results();
			end
			send_request(c, k);
		end
		drain_results();
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			dir_keys[i] = '0;
			dir_valid[i] = 1'b0;
			dir_order[i] = i;
		end
		dir_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_directory();
		test_fill_and_hit();
		test_duplicate_keys();
		test_eviction();
		test_random_traffic(408, 0, 0);
		test_random_traffic(408, 88, 0);
		test_random_traffic(408, 0, 88);
		test_random_traffic(408, 24, 24);

		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/lkcd_pkg.sv
rtl/lkcd_cell.sv
rtl/lru_key_cache_directory.sv
tb/tb.sv
